// File: hdl/mtq_pkg.sv
// Types and constants shared by the two-queue replacement block.
`default_nettype none
package mtq_pkg;

  localparam int NUM_TENANTS = 4;
  localparam int NUM_LOC     = 1024;
  localparam int GHOST_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int PTR_W       = 11;
  localparam int PAGE_W      = 24;

  localparam logic [PTR_W-1:0] NUM_LOC_C     = 11'd1024;
  localparam logic [PTR_W-1:0] GHOST_DEPTH_C = 11'd1024;

  // commands
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_TOUCH  = 3'd1;
  localparam logic [2:0] CMD_ADD    = 3'd2;
  localparam logic [2:0] CMD_EVICT  = 3'd3;
  localparam logic [2:0] CMD_ALLOC  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  // queue kinds per tenant
  localparam logic [1:0] K_A1IN = 2'd0;
  localparam logic [1:0] K_AM   = 2'd1;
  localparam logic [1:0] K_OUT  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_TOTAL  = 3'd0;
  localparam logic [2:0] CFG_A1IN   = 3'd1;
  localparam logic [2:0] CFG_A1OUT  = 3'd2;
  localparam logic [2:0] CFG_BASE_1 = 3'd3;
  localparam logic [2:0] CFG_BASE_2 = 3'd4;
  localparam logic [2:0] CFG_BASE_3 = 3'd5;
  localparam logic [2:0] CFG_BASE_4 = 3'd6;

  typedef struct packed {
    logic              valid;
    logic [1:0]        tenant;
    logic [PAGE_W-1:0] page;
    logic              in_am;
    logic [PTR_W-1:0]  link_prev;
    logic [PTR_W-1:0]  link_next;
  } res_word_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        tenant;
    logic [PAGE_W-1:0] page;
    logic [PTR_W-1:0]  link_prev;
    logic [PTR_W-1:0]  link_next;
  } ghost_word_t;

  // pointers are 1-based ids, 0 is null
  function automatic logic [ADDR_W-1:0] id_addr(input logic [PTR_W-1:0] id);
    logic [PTR_W-1:0] d;
    d = id - 11'd1;
    return d[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/mtq_in_if.sv
// Command channel interface.
`default_nettype none
interface mtq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  tenant;
  logic [23:0] page;
  logic [10:0] location;
  modport source (output valid, cmd, tenant, page, location, input ready);
  modport sink (input valid, cmd, tenant, page, location, output ready);
endinterface
`default_nettype wire

// File: hdl/mtq_out_if.sv
// Result channel interface.
`default_nettype none
interface mtq_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [10:0] result_location;
  logic [23:0] evicted_page;
  logic [1:0]  status;
  modport source (output valid, hit, result_location, evicted_page, status, input ready);
  modport sink (input valid, hit, result_location, evicted_page, status, output ready);
endinterface
`default_nettype wire

// File: hdl/multi_tenant_two_queue_replacement.sv
// Per-tenant 2Q replacement engine: resident and ghost tables in synchronous RAMs.
// One command at a time. After reset a clearing pass sweeps the resident valid
// bits while in_ch.ready stays low. Lookup, touch and add scan the resident RAM
// one entry per cycle; add then scans the filled part of the ghost RAM. Evict and
// the list relinking do a read-modify-write of each neighbor link through the
// single read port of each RAM. A finished result waits in the output register
// while the next command is taken.
`default_nettype none
module multi_tenant_two_queue_replacement (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mtq_in_if.sink           in_ch,
  mtq_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RSCAN, S_ARD, S_ACHK, S_GSCAN, S_FX_RD, S_FX_WR,
    S_RUNL, S_RUNL2, S_RAFT, S_RPUSH, S_EV0, S_EV1, S_EVRD, S_EV2, S_EVFIN,
    S_GADD0, S_GADD1, S_GADD2, S_GLIM, S_GDROP, S_GDRD, S_GUNL, S_GUNL2,
    S_GFREE, S_DONE
  } state_t;

  state_t state_r, fx_ret_r;

  // configuration
  logic [10:0] total_r;
  logic [8:0]  a1in_r, a1out_r;
  logic [10:0] base_r [mtq_pkg::NUM_TENANTS];

  // memories
  mtq_pkg::res_word_t   res_mem   [mtq_pkg::NUM_LOC];
  mtq_pkg::ghost_word_t ghost_mem [mtq_pkg::GHOST_DEPTH];
  mtq_pkg::res_word_t   res_rdata_r, res_wdata, rw_r;
  mtq_pkg::ghost_word_t ghost_rdata_r, ghost_wdata, gw_r;
  logic res_re, res_we, ghost_re, ghost_we;
  logic [mtq_pkg::ADDR_W-1:0] res_raddr, res_waddr, ghost_raddr, ghost_waddr;

  // list heads, tails, counts
  logic [10:0] head_r [mtq_pkg::NUM_TENANTS][3];
  logic [10:0] tail_r [mtq_pkg::NUM_TENANTS][3];
  logic [10:0] cnt_r  [mtq_pkg::NUM_TENANTS][3];

  logic [10:0] next_fresh_r, gfill_r, gused_r, free_r;
  logic [9:0]  clr_r;
  logic [10:0] scan_r, pend_idx_r;
  logic        pend_r;

  // transaction context
  logic [2:0]  cmd_r;
  logic [1:0]  t_r;
  logic [23:0] pg_r;
  logic [10:0] loc_r;
  logic [1:0]  kq_r;
  logic        fa_r;
  logic [10:0] s_r, g_r;
  logic [20:0] prod_r;

  // neighbor link update
  logic        fx_ghost_r, fx_prev_r;
  logic [10:0] fx_addr_r, fx_val_r;

  // result
  logic        hit_r;
  logic [10:0] rloc_r;
  logic [23:0] epg_r;
  logic [1:0]  st_r;
  logic        out_valid_r, o_hit_r;
  logic [10:0] o_loc_r;
  logic [23:0] o_epg_r;
  logic [1:0]  o_st_r;

  logic        tok, match_res, match_ghost, fa;
  logic [10:0] na, nm, lim;
  logic [11:0] nsum;

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = o_hit_r;
  assign out_ch.result_location = o_loc_r;
  assign out_ch.evicted_page    = o_epg_r;
  assign out_ch.status          = o_st_r;

  assign tok = (in_ch.tenant >= 3'd1) && (in_ch.tenant <= 3'd4);
  assign lim = (total_r < mtq_pkg::NUM_LOC_C) ? total_r : mtq_pkg::NUM_LOC_C;
  assign na  = cnt_r[t_r][mtq_pkg::K_A1IN];
  assign nm  = cnt_r[t_r][mtq_pkg::K_AM];
  assign nsum = {1'b0, na} + {1'b0, nm};
  assign fa  = (({2'b0, na, 8'b0} > prod_r) && (na != 11'd0)) || (nm == 11'd0);
  assign match_res = res_rdata_r.valid && (res_rdata_r.tenant == t_r) &&
                     (res_rdata_r.page == pg_r);
  assign match_ghost = ghost_rdata_r.valid && (ghost_rdata_r.tenant == t_r) &&
                       (ghost_rdata_r.page == pg_r);

  // RAM ports
  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_rdata_r <= res_mem[res_raddr];
    if (ghost_we) ghost_mem[ghost_waddr] <= ghost_wdata;
    if (ghost_re) ghost_rdata_r <= ghost_mem[ghost_raddr];
  end

  always_comb begin
    res_re = 1'b0; res_raddr = '0; res_we = 1'b0; res_waddr = '0; res_wdata = '0;
    ghost_re = 1'b0; ghost_raddr = '0; ghost_we = 1'b0; ghost_waddr = '0;
    ghost_wdata = '0;
    case (state_r)
      S_CLR: begin
        res_we = 1'b1; res_waddr = clr_r;
      end
      S_RSCAN: begin
        res_re = (scan_r < mtq_pkg::NUM_LOC_C); res_raddr = scan_r[9:0];
      end
      S_ARD: begin
        res_re = 1'b1; res_raddr = mtq_pkg::id_addr(loc_r);
      end
      S_GSCAN: begin
        ghost_re = (scan_r < gfill_r); ghost_raddr = scan_r[9:0];
      end
      S_FX_RD: begin
        res_re = !fx_ghost_r; ghost_re = fx_ghost_r;
        res_raddr = mtq_pkg::id_addr(fx_addr_r); ghost_raddr = mtq_pkg::id_addr(fx_addr_r);
      end
      S_FX_WR: begin
        res_wdata = res_rdata_r; ghost_wdata = ghost_rdata_r;
        if (fx_prev_r) begin
          res_wdata.link_prev = fx_val_r; ghost_wdata.link_prev = fx_val_r;
        end else begin
          res_wdata.link_next = fx_val_r; ghost_wdata.link_next = fx_val_r;
        end
        res_we = !fx_ghost_r; ghost_we = fx_ghost_r;
        res_waddr = mtq_pkg::id_addr(fx_addr_r); ghost_waddr = mtq_pkg::id_addr(fx_addr_r);
      end
      S_RPUSH: begin
        res_we = 1'b1; res_waddr = mtq_pkg::id_addr(s_r);
        res_wdata.valid = 1'b1; res_wdata.tenant = t_r; res_wdata.page = pg_r;
        res_wdata.in_am = (kq_r == mtq_pkg::K_AM);
        res_wdata.link_next = head_r[t_r][kq_r];
      end
      S_EVRD: begin
        res_re = 1'b1; res_raddr = mtq_pkg::id_addr(s_r);
      end
      S_EVFIN: begin
        res_we = 1'b1; res_waddr = mtq_pkg::id_addr(s_r);
        res_wdata = rw_r; res_wdata.valid = 1'b0;
      end
      S_GADD0: begin
        ghost_re = (free_r != 11'd0); ghost_raddr = mtq_pkg::id_addr(free_r);
      end
      S_GADD2: begin
        ghost_we = 1'b1; ghost_waddr = mtq_pkg::id_addr(g_r);
        ghost_wdata.valid = 1'b1; ghost_wdata.tenant = t_r; ghost_wdata.page = pg_r;
        ghost_wdata.link_next = head_r[t_r][mtq_pkg::K_OUT];
      end
      S_GDROP: begin
        ghost_re = 1'b1; ghost_raddr = mtq_pkg::id_addr(tail_r[t_r][mtq_pkg::K_OUT]);
      end
      S_GFREE: begin
        ghost_we = 1'b1; ghost_waddr = mtq_pkg::id_addr(g_r);
        ghost_wdata.link_next = free_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      fx_ret_r <= S_DONE;
      total_r <= 11'd1024; a1in_r <= 9'd64; a1out_r <= 9'd128;
      for (int i = 0; i < mtq_pkg::NUM_TENANTS; i++) begin
        base_r[i] <= 11'd256;
        for (int k = 0; k < 3; k++) begin
          head_r[i][k] <= '0; tail_r[i][k] <= '0; cnt_r[i][k] <= '0;
        end
      end
      next_fresh_r <= 11'd1;
      gfill_r <= '0; gused_r <= '0; free_r <= '0;
      clr_r <= '0; scan_r <= '0; pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mtq_pkg::CFG_TOTAL:  total_r <= cfg_wdata;
          mtq_pkg::CFG_A1IN:   a1in_r <= cfg_wdata[8:0];
          mtq_pkg::CFG_A1OUT:  a1out_r <= cfg_wdata[8:0];
          mtq_pkg::CFG_BASE_1: base_r[0] <= cfg_wdata;
          mtq_pkg::CFG_BASE_2: base_r[1] <= cfg_wdata;
          mtq_pkg::CFG_BASE_3: base_r[2] <= cfg_wdata;
          mtq_pkg::CFG_BASE_4: base_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 10'd1;
          if (clr_r == 10'(mtq_pkg::NUM_LOC - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r <= in_ch.cmd; t_r <= 2'(in_ch.tenant - 3'd1);
            pg_r <= in_ch.page; loc_r <= in_ch.location;
            hit_r <= 1'b0; rloc_r <= '0; epg_r <= '0; st_r <= mtq_pkg::ST_MISS;
            scan_r <= '0; pend_r <= 1'b0;
            state_r <= S_DONE;
            case (in_ch.cmd)
              mtq_pkg::CMD_ALLOC: begin
                if (next_fresh_r <= lim) begin
                  rloc_r <= next_fresh_r; next_fresh_r <= next_fresh_r + 11'd1;
                  st_r <= mtq_pkg::ST_OK;
                end else begin
                  st_r <= mtq_pkg::ST_FULL;
                end
              end
              mtq_pkg::CMD_LOOKUP, mtq_pkg::CMD_TOUCH, mtq_pkg::CMD_ADD:
                if (tok) state_r <= S_RSCAN;
              mtq_pkg::CMD_EVICT:
                if (tok) state_r <= S_EV0;
              default: ;
            endcase
          end
        end
        S_RSCAN: begin
          if (scan_r < mtq_pkg::NUM_LOC_C) scan_r <= scan_r + 11'd1;
          pend_r <= (scan_r < mtq_pkg::NUM_LOC_C);
          pend_idx_r <= scan_r;
          if (pend_r && match_res) begin
            rw_r <= res_rdata_r;
            s_r <= pend_idx_r + 11'd1;
            kq_r <= mtq_pkg::K_AM;
            if (cmd_r == mtq_pkg::CMD_ADD) begin
              st_r <= mtq_pkg::ST_DUP; state_r <= S_DONE;
            end else begin
              hit_r <= 1'b1; rloc_r <= pend_idx_r + 11'd1; st_r <= mtq_pkg::ST_OK;
              // on touch, move an Am hit to the MRU end
              state_r <= (cmd_r == mtq_pkg::CMD_TOUCH && res_rdata_r.in_am) ? S_RUNL
                                                                             : S_DONE;
            end
          end else if (!pend_r && scan_r >= mtq_pkg::NUM_LOC_C) begin
            if (cmd_r != mtq_pkg::CMD_ADD) state_r <= S_DONE;
            else if (loc_r == 11'd0 || loc_r > mtq_pkg::NUM_LOC_C) begin
              st_r <= mtq_pkg::ST_FULL; state_r <= S_DONE;
            end else state_r <= S_ARD;
          end
        end
        S_ARD: state_r <= S_ACHK;
        S_ACHK: begin
          if (res_rdata_r.valid) begin
            st_r <= mtq_pkg::ST_FULL; state_r <= S_DONE;
          end else begin
            rloc_r <= loc_r; st_r <= mtq_pkg::ST_OK; s_r <= loc_r;
            scan_r <= '0; pend_r <= 1'b0;
            state_r <= S_GSCAN;
          end
        end
        S_GSCAN: begin
          if (scan_r < gfill_r) scan_r <= scan_r + 11'd1;
          pend_r <= (scan_r < gfill_r);
          pend_idx_r <= scan_r;
          if (pend_r && match_ghost) begin
            gw_r <= ghost_rdata_r; g_r <= pend_idx_r + 11'd1;
            kq_r <= mtq_pkg::K_AM; state_r <= S_GUNL;
          end else if (!pend_r && scan_r >= gfill_r) begin
            kq_r <= mtq_pkg::K_A1IN; state_r <= S_RPUSH;
          end
        end
        S_FX_RD: state_r <= S_FX_WR;
        S_FX_WR: state_r <= fx_ret_r;
        S_RUNL: begin
          cnt_r[t_r][kq_r] <= cnt_r[t_r][kq_r] - 11'd1;
          if (rw_r.link_prev != 11'd0) begin
            fx_ghost_r <= 1'b0; fx_prev_r <= 1'b0; fx_addr_r <= rw_r.link_prev;
            fx_val_r <= rw_r.link_next; fx_ret_r <= S_RUNL2; state_r <= S_FX_RD;
          end else begin
            head_r[t_r][kq_r] <= rw_r.link_next; state_r <= S_RUNL2;
          end
        end
        S_RUNL2: begin
          if (rw_r.link_next != 11'd0) begin
            fx_ghost_r <= 1'b0; fx_prev_r <= 1'b1; fx_addr_r <= rw_r.link_next;
            fx_val_r <= rw_r.link_prev; fx_ret_r <= S_RAFT; state_r <= S_FX_RD;
          end else begin
            tail_r[t_r][kq_r] <= rw_r.link_prev; state_r <= S_RAFT;
          end
        end
        S_RAFT: state_r <= (cmd_r == mtq_pkg::CMD_TOUCH) ? S_RPUSH : S_EVFIN;
        S_RPUSH: begin
          head_r[t_r][kq_r] <= s_r;
          cnt_r[t_r][kq_r] <= cnt_r[t_r][kq_r] + 11'd1;
          if (head_r[t_r][kq_r] != 11'd0) begin
            fx_ghost_r <= 1'b0; fx_prev_r <= 1'b1; fx_addr_r <= head_r[t_r][kq_r];
            fx_val_r <= s_r; fx_ret_r <= S_DONE; state_r <= S_FX_RD;
          end else begin
            tail_r[t_r][kq_r] <= s_r; state_r <= S_DONE;
          end
        end
        S_EV0: begin
          if (nsum == 12'd0) state_r <= S_DONE;
          else begin
            prod_r <= {9'b0, nsum} * {12'b0, a1in_r};
            state_r <= S_EV1;
          end
        end
        S_EV1: begin
          fa_r <= fa;
          kq_r <= fa ? mtq_pkg::K_A1IN : mtq_pkg::K_AM;
          s_r <= fa ? tail_r[t_r][mtq_pkg::K_A1IN] : tail_r[t_r][mtq_pkg::K_AM];
          state_r <= S_EVRD;
        end
        S_EVRD: state_r <= S_EV2;
        S_EV2: begin
          rw_r <= res_rdata_r; pg_r <= res_rdata_r.page;
          rloc_r <= s_r; epg_r <= res_rdata_r.page; st_r <= mtq_pkg::ST_OK;
          state_r <= S_RUNL;
        end
        S_EVFIN: begin
          prod_r <= {10'b0, base_r[t_r]} * {12'b0, a1out_r};
          state_r <= fa_r ? S_GADD0 : S_DONE;
        end
        S_GADD0: begin
          if (gused_r == mtq_pkg::GHOST_DEPTH_C) state_r <= S_DONE;
          else if (free_r != 11'd0) begin
            g_r <= free_r; state_r <= S_GADD1;
          end else begin
            g_r <= gfill_r + 11'd1; gfill_r <= gfill_r + 11'd1; state_r <= S_GADD2;
          end
        end
        S_GADD1: begin
          free_r <= ghost_rdata_r.link_next; state_r <= S_GADD2;
        end
        S_GADD2: begin
          head_r[t_r][mtq_pkg::K_OUT] <= g_r;
          cnt_r[t_r][mtq_pkg::K_OUT] <= cnt_r[t_r][mtq_pkg::K_OUT] + 11'd1;
          gused_r <= gused_r + 11'd1;
          if (head_r[t_r][mtq_pkg::K_OUT] != 11'd0) begin
            fx_ghost_r <= 1'b1; fx_prev_r <= 1'b1;
            fx_addr_r <= head_r[t_r][mtq_pkg::K_OUT];
            fx_val_r <= g_r; fx_ret_r <= S_GLIM; state_r <= S_FX_RD;
          end else begin
            tail_r[t_r][mtq_pkg::K_OUT] <= g_r; state_r <= S_GLIM;
          end
        end
        S_GLIM: begin
          // drop the oldest ghost once the list passes its limit
          if ({2'b0, cnt_r[t_r][mtq_pkg::K_OUT], 8'b0} > prod_r) state_r <= S_GDROP;
          else state_r <= S_DONE;
        end
        S_GDROP: begin
          g_r <= tail_r[t_r][mtq_pkg::K_OUT]; state_r <= S_GDRD;
        end
        S_GDRD: begin
          gw_r <= ghost_rdata_r; state_r <= S_GUNL;
        end
        S_GUNL: begin
          cnt_r[t_r][mtq_pkg::K_OUT] <= cnt_r[t_r][mtq_pkg::K_OUT] - 11'd1;
          if (gw_r.link_prev != 11'd0) begin
            fx_ghost_r <= 1'b1; fx_prev_r <= 1'b0; fx_addr_r <= gw_r.link_prev;
            fx_val_r <= gw_r.link_next; fx_ret_r <= S_GUNL2; state_r <= S_FX_RD;
          end else begin
            head_r[t_r][mtq_pkg::K_OUT] <= gw_r.link_next; state_r <= S_GUNL2;
          end
        end
        S_GUNL2: begin
          if (gw_r.link_next != 11'd0) begin
            fx_ghost_r <= 1'b1; fx_prev_r <= 1'b1; fx_addr_r <= gw_r.link_next;
            fx_val_r <= gw_r.link_prev; fx_ret_r <= S_GFREE; state_r <= S_FX_RD;
          end else begin
            tail_r[t_r][mtq_pkg::K_OUT] <= gw_r.link_prev; state_r <= S_GFREE;
          end
        end
        S_GFREE: begin
          free_r <= g_r; gused_r <= gused_r - 11'd1;
          state_r <= (cmd_r == mtq_pkg::CMD_ADD) ? S_RPUSH : S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_hit_r <= hit_r; o_loc_r <= rloc_r; o_epg_r <= epg_r; o_st_r <= st_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fx_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FX_RD) |-> (fx_addr_r != 11'd0))
    else $error("link update to null pointer");

  a_ghost_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (gused_r <= gfill_r) && (gfill_r <= mtq_pkg::GHOST_DEPTH_C))
    else $error("ghost occupancy out of range");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> (out_ch.status == mtq_pkg::ST_OK))
    else $error("hit with bad status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction taken while busy");

endmodule
`default_nettype wire

// File: tb/mtq_tb_if.sv
// Testbench note: channel interfaces are the RTL's own mtq_in_if and mtq_out_if.
`timescale 1ns / 100ps
package mtq_tb_pkg;
  localparam int WATCHDOG_LIMIT = 40000;
endpackage

// File: tb/multi_tenant_two_queue_replacement_tb.sv
// Testbench for the per-tenant 2Q replacement block: self-predicting, random idling.
`timescale 1ns / 100ps
module multi_tenant_two_queue_replacement_tb;

  typedef struct packed {
    logic        hit;
    logic [10:0] loc;
    logic [23:0] epg;
    logic [1:0]  status;
  } answer_t;

  localparam int NIL = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = mtq_pkg::CFG_TOTAL;
  logic [10:0] cfg_wdata = '0;

  mtq_in_if in_ch();
  mtq_out_if out_ch();

  multi_tenant_two_queue_replacement i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned lim_total, ratio_a1in, ratio_a1out;
  int unsigned base_sz[4];
  bit          rv[mtq_pkg::NUM_LOC];
  int unsigned rt[mtq_pkg::NUM_LOC];
  int unsigned rp[mtq_pkg::NUM_LOC];
  bit          ram[mtq_pkg::NUM_LOC];
  int          rprev[mtq_pkg::NUM_LOC], rnext[mtq_pkg::NUM_LOC];
  bit          gv[mtq_pkg::GHOST_DEPTH];
  int unsigned gt[mtq_pkg::GHOST_DEPTH];
  int unsigned gp[mtq_pkg::GHOST_DEPTH];
  int          gprev[mtq_pkg::GHOST_DEPTH], gnext[mtq_pkg::GHOST_DEPTH];
  int          qhead[12], qtail[12];
  int unsigned qcnt[12];
  int unsigned fresh_loc;

  answer_t expected_answers[$];
  int errors = 0, mismatches = 0, results_seen = 0, items_sent = 0;
  int idle_cycles = 0;
  int pages_used[$];

  function automatic void push_res(int q, int s);
    rprev[s] = NIL; rnext[s] = qhead[q];
    if (qhead[q] != NIL) rprev[qhead[q]] = s; else qtail[q] = s;
    qhead[q] = s; qcnt[q]++;
  endfunction

  function automatic void unlink_res(int q, int s);
    int p, n;
    p = rprev[s]; n = rnext[s];
    if (p != NIL) rnext[p] = n; else qhead[q] = n;
    if (n != NIL) rprev[n] = p; else qtail[q] = p;
    qcnt[q]--;
  endfunction

  function automatic void push_ghost(int q, int s);
    gprev[s] = NIL; gnext[s] = qhead[q];
    if (qhead[q] != NIL) gprev[qhead[q]] = s; else qtail[q] = s;
    qhead[q] = s; qcnt[q]++;
  endfunction

  function automatic void unlink_ghost(int q, int s);
    int p, n;
    p = gprev[s]; n = gnext[s];
    if (p != NIL) gnext[p] = n; else qhead[q] = n;
    if (n != NIL) gprev[n] = p; else qtail[q] = p;
    qcnt[q]--;
  endfunction

  function automatic int find_resident(int unsigned t, int unsigned pg);
    for (int i = 0; i < mtq_pkg::NUM_LOC; i++)
      if (rv[i] && rt[i] == t && rp[i] == pg) return i;
    return NIL;
  endfunction

  function automatic int find_ghost(int unsigned t, int unsigned pg);
    for (int i = 0; i < mtq_pkg::GHOST_DEPTH; i++)
      if (gv[i] && gt[i] == t && gp[i] == pg) return i;
    return NIL;
  endfunction

  function automatic void record_ghost(int unsigned t, int unsigned pg);
    int q, s, tl;
    q = t * 3 + mtq_pkg::K_OUT; s = NIL;
    for (int i = 0; i < mtq_pkg::GHOST_DEPTH; i++)
      if (!gv[i]) begin s = i; break; end
    if (s == NIL) return;
    gv[s] = 1; gt[s] = t; gp[s] = pg;
    push_ghost(q, s);
    if (longint'(qcnt[q]) * 256 > longint'(base_sz[t]) * ratio_a1out) begin
      tl = qtail[q];
      unlink_ghost(q, tl);
      gv[tl] = 0;
    end
  endfunction

  function automatic void reset_model();
    lim_total = 1024; ratio_a1in = 64; ratio_a1out = 128;
    foreach (base_sz[i]) base_sz[i] = 256;
    foreach (rv[i]) rv[i] = 0;
    foreach (gv[i]) gv[i] = 0;
    foreach (qhead[i]) begin qhead[i] = NIL; qtail[i] = NIL; qcnt[i] = 0; end
    fresh_loc = 1;
  endfunction

  function automatic answer_t replace_step(logic [2:0] cmd, logic [2:0] tn,
                                           logic [23:0] pg, logic [10:0] loc);
    answer_t a;
    int unsigned t, lim;
    int s, g, q, qa, qm;
    longint na, nm;
    bit from_a1;
    a = '0; a.status = mtq_pkg::ST_MISS;
    t = (tn >= 1 && tn <= mtq_pkg::NUM_TENANTS) ? tn - 1 : 0;
    if (cmd == mtq_pkg::CMD_ALLOC) begin
      lim = lim_total < mtq_pkg::NUM_LOC ? lim_total : mtq_pkg::NUM_LOC;
      if (fresh_loc <= lim) begin
        a.loc = 11'(fresh_loc); fresh_loc++; a.status = mtq_pkg::ST_OK;
      end else a.status = mtq_pkg::ST_FULL;
    end else if (cmd <= mtq_pkg::CMD_EVICT && tn >= 1 && tn <= mtq_pkg::NUM_TENANTS) begin
      if (cmd == mtq_pkg::CMD_LOOKUP || cmd == mtq_pkg::CMD_TOUCH) begin
        s = find_resident(t, pg);
        if (s != NIL) begin
          a.hit = 1'b1; a.loc = 11'(s + 1); a.status = mtq_pkg::ST_OK;
          if (cmd == mtq_pkg::CMD_TOUCH && ram[s]) begin
            q = t * 3 + mtq_pkg::K_AM;
            unlink_res(q, s); push_res(q, s);
          end
        end
      end else if (cmd == mtq_pkg::CMD_ADD) begin
        if (find_resident(t, pg) != NIL) a.status = mtq_pkg::ST_DUP;
        else if (loc == 0 || loc > mtq_pkg::NUM_LOC || rv[loc - 1])
          a.status = mtq_pkg::ST_FULL;
        else begin
          g = find_ghost(t, pg);
          s = loc - 1;
          rv[s] = 1; rt[s] = t; rp[s] = pg;
          if (g != NIL) begin
            unlink_ghost(t * 3 + mtq_pkg::K_OUT, g); gv[g] = 0;
            ram[s] = 1; push_res(t * 3 + mtq_pkg::K_AM, s);
          end else begin
            ram[s] = 0; push_res(t * 3 + mtq_pkg::K_A1IN, s);
          end
          a.loc = loc; a.status = mtq_pkg::ST_OK;
        end
      end else begin
        qa = t * 3 + mtq_pkg::K_A1IN; qm = t * 3 + mtq_pkg::K_AM;
        na = qcnt[qa]; nm = qcnt[qm];
        if (na + nm != 0) begin
          from_a1 = (na * 256 > (na + nm) * ratio_a1in && na != 0) || nm == 0;
          q = from_a1 ? qa : qm;
          s = qtail[q];
          unlink_res(q, s);
          rv[s] = 0;
          a.loc = 11'(s + 1); a.epg = 24'(rp[s]); a.status = mtq_pkg::ST_OK;
          if (from_a1) record_ghost(t, rp[s]);
        end
      end
    end
    return a;
  endfunction

  // hold valid high across back-to-back commands; drop it only for a gap
  task automatic send_command(logic [2:0] cmd, logic [2:0] tn,
                              logic [23:0] pg, logic [10:0] loc);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.cmd <= cmd; in_ch.tenant <= tn;
    in_ch.page <= pg; in_ch.location <= loc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_answers.push_back(replace_step(cmd, tn, pg, loc));
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, int unsigned val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mtq_pkg::CFG_TOTAL: lim_total = val & 'h7ff;
      mtq_pkg::CFG_A1IN:  ratio_a1in = val & 'h1ff;
      mtq_pkg::CFG_A1OUT: ratio_a1out = val & 'h1ff;
      default:            base_sz[idx - mtq_pkg::CFG_BASE_1] = val & 'h7ff;
    endcase
  endtask

  function automatic logic [10:0] free_location();
    for (int k = 0; k < 8; k++) begin
      int l;
      l = $urandom_range(1, mtq_pkg::NUM_LOC);
      if (!rv[l - 1]) return 11'(l);
    end
    return $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1, 2047));
  endfunction

  function automatic logic [23:0] pick_page();
    if (pages_used.size() != 0 && $urandom_range(0, 3) != 0)
      return 24'(pages_used[$urandom_range(0, pages_used.size() - 1)]);
    return 24'($urandom);
  endfunction

  // result checker with random backpressure
  always @(posedge clk) begin
    answer_t want;
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_answers.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transaction");
      end else begin
        want = expected_answers.pop_front();
        if (out_ch.hit !== want.hit || out_ch.result_location !== want.loc ||
            out_ch.evicted_page !== want.epg || out_ch.status !== want.status) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp hit %0d loc %0d page %h st %0d, got %0d %0d %h %0d",
                     want.hit, want.loc, want.epg, want.status, out_ch.hit,
                     out_ch.result_location, out_ch.evicted_page, out_ch.status);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (out_ch.valid && out_ch.ready || stall_left == 0 && !out_ch.ready) begin
      if (out_ch.valid && out_ch.ready) begin
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end else out_ch.ready <= 1'b1;
    end else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // watchdog: counts cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= mtq_tb_pkg::WATCHDOG_LIMIT) begin
      $display("multi_tenant_two_queue_replacement verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(mtq_pkg::CMD_ALLOC, 3'd0, 24'd0, 11'd0);
    send_command(mtq_pkg::CMD_LOOKUP, 3'd1, 24'hFFFFFF, 11'd0);
    send_command(mtq_pkg::CMD_ADD, 3'd1, 24'hFFFFFF, 11'd1);
    send_command(mtq_pkg::CMD_ADD, 3'd1, 24'hFFFFFF, 11'd2);
    send_command(mtq_pkg::CMD_ADD, 3'd2, 24'h000000, 11'd1);
    send_command(mtq_pkg::CMD_ADD, 3'd2, 24'h000000, 11'd0);
    send_command(mtq_pkg::CMD_ADD, 3'd2, 24'h000000, 11'd1025);
    send_command(mtq_pkg::CMD_ADD, 3'd4, 24'h000000, 11'd1024);
    send_command(mtq_pkg::CMD_LOOKUP, 3'd1, 24'hFFFFFF, 11'h7FF);
    send_command(mtq_pkg::CMD_TOUCH, 3'd1, 24'hFFFFFF, 11'd0);
    send_command(mtq_pkg::CMD_TOUCH, 3'd3, 24'h123456, 11'd0);
    send_command(mtq_pkg::CMD_LOOKUP, 3'd0, 24'hFFFFFF, 11'd0);
    send_command(mtq_pkg::CMD_LOOKUP, 3'd7, 24'hFFFFFF, 11'd0);
    send_command(3'd5, 3'd1, 24'hFFFFFF, 11'd0);
    send_command(3'd7, 3'd1, 24'hFFFFFF, 11'd0);
    send_command(mtq_pkg::CMD_EVICT, 3'd1, 24'd0, 11'd0);
    send_command(mtq_pkg::CMD_ADD, 3'd1, 24'hFFFFFF, 11'd5);
    send_command(mtq_pkg::CMD_TOUCH, 3'd1, 24'hFFFFFF, 11'd0);
    send_command(mtq_pkg::CMD_EVICT, 3'd1, 24'd0, 11'd0);
    send_command(mtq_pkg::CMD_EVICT, 3'd3, 24'd0, 11'd0);
    send_command(mtq_pkg::CMD_EVICT, 3'd5, 24'd0, 11'd0);
    send_command(mtq_pkg::CMD_ALLOC, 3'd6, 24'd0, 11'd0);
    drain_results();
  endtask

  task automatic run_random(int n, int unsigned page_span);
    logic [2:0] cmd, tn;
    logic [23:0] pg;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      tn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      pg = (page_span != 0) ? 24'($urandom_range(0, page_span)) : pick_page();
      if (r < 35) begin
        send_command(mtq_pkg::CMD_ADD, tn, pg, free_location());
        pages_used.push_back(pg);
      end else if (r < 55) send_command(mtq_pkg::CMD_EVICT, tn, pg, 11'($urandom));
      else if (r < 70) send_command(mtq_pkg::CMD_LOOKUP, tn, pg, 11'($urandom));
      else if (r < 85) send_command(mtq_pkg::CMD_TOUCH, tn, pg, 11'($urandom));
      else if (r < 95) send_command(mtq_pkg::CMD_ALLOC, tn, pg, 11'($urandom));
      else send_command(3'($urandom_range(5, 7)), tn, pg, 11'($urandom));
    end
    drain_results();
  endtask

  task automatic test_default_settings();
    run_random(250, 0);
  endtask

  task automatic test_extreme_settings();
    write_register(mtq_pkg::CFG_TOTAL, 1);
    write_register(mtq_pkg::CFG_A1IN, 0);
    write_register(mtq_pkg::CFG_A1OUT, 256);
    write_register(mtq_pkg::CFG_BASE_1, 0);
    write_register(mtq_pkg::CFG_BASE_2, 1024);
    write_register(mtq_pkg::CFG_BASE_3, 2047);
    write_register(mtq_pkg::CFG_BASE_4, 3);
    run_random(220, 40);
    write_register(mtq_pkg::CFG_TOTAL, 2047);
    write_register(mtq_pkg::CFG_A1IN, 256);
    write_register(mtq_pkg::CFG_A1OUT, 0);
    write_register(mtq_pkg::CFG_BASE_1, 1024);
    run_random(220, 40);
    write_register(mtq_pkg::CFG_TOTAL, 1024);
    write_register(mtq_pkg::CFG_A1IN, 511);
    write_register(mtq_pkg::CFG_A1OUT, 511);
    write_register(mtq_pkg::CFG_BASE_4, 0);
    write_register(mtq_pkg::CFG_BASE_2, 5);
    run_random(240, 0);
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.cmd = mtq_pkg::CMD_LOOKUP; in_ch.tenant = '0;
    in_ch.page = '0; in_ch.location = '0;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_default_settings();
    test_extreme_settings();
    $display("sent %0d commands, checked %0d results over four register settings",
             items_sent, results_seen);
    if (errors == 0 && expected_answers.size() == 0)
      $display("multi_tenant_two_queue_replacement verification clean");
    else
      $display("multi_tenant_two_queue_replacement verification failed");
    $finish;
  end
endmodule
